### sv/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants for the bounded array list: command and status
// codes, stream beat widths and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bal_pkg;

    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int FIDX_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_FIND   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic [FIDX_W-1:0]        found_index;
        logic signed [WORD_W-1:0] data;
        t_status                  status;
    } t_result;

endpackage

### sv/bal_ram.sv
// ----------------------------------------------------------------------------
// bal_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl
// Command sequencer: holds the list length, walks the entry RAM one entry a
// cycle for shifts and searches, and produces one result per command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bal_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  bal_pkg::t_cmd                   i_cmd,
    input  logic [bal_pkg::POS_W-1:0]       i_pos,
    input  logic signed [bal_pkg::WORD_W-1:0] i_val,
    input  logic                            i_out_free,
    output logic                            o_idle,
    output logic                            o_res_valid,
    output bal_pkg::t_result                o_res,
    output logic                            o_ram_we,
    output logic [$clog2(CAPACITY)-1:0]     o_ram_waddr,
    output logic [bal_pkg::WORD_W-1:0]      o_ram_wdata,
    output logic                            o_ram_re,
    output logic [$clog2(CAPACITY)-1:0]     o_ram_raddr,
    input  logic [bal_pkg::WORD_W-1:0]      i_ram_rdata
);

    import bal_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_UP   = 7'b0000010,
        S_PUT  = 7'b0000100,
        S_DOWN = 7'b0001000,
        S_GET  = 7'b0010000,
        S_FIND = 7'b0100000,
        S_RESP = 7'b1000000
    } t_state;

    t_state                   r_state,  n_state;
    logic [CW-1:0]            r_count,  n_count;
    logic [IW-1:0]            r_idx,    n_idx;
    logic [IW-1:0]            r_pos,    n_pos;
    logic [WORD_W-1:0]        r_val,    n_val;
    t_status                  r_status, n_status;
    logic [WORD_W-1:0]        r_data,   n_data;
    logic [FIDX_W-1:0]        r_fidx,   n_fidx;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic [IW-1:0] cnt_last;

    assign pos_x    = XW'(i_pos);
    assign cnt_x    = XW'(r_count);
    assign cnt_last = IW'(r_count - CW'(1));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_val       = r_val;
        n_status    = r_status;
        n_data      = r_data;
        n_fidx      = r_fidx;
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = '0;
        o_ram_re    = 1'b0;
        o_ram_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_val    = i_val;
                    n_pos    = IW'(pos_x);
                    n_status = ST_OK;
                    n_data   = '0;
                    n_fidx   = '0;
                    n_state  = S_RESP;
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (pos_x > XW'(CAPACITY)) begin
                                n_status = ST_BAD_POS;
                            end else if (r_count == CW'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (pos_x >= cnt_x) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = IW'(r_count);
                                o_ram_wdata = i_val;
                                n_count     = r_count + CW'(1);
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = cnt_last;
                                n_idx       = cnt_last;
                                n_state     = S_UP;
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (pos_x >= cnt_x) begin
                                n_status = ST_BAD_POS;
                            end else if (IW'(pos_x) == cnt_last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = IW'(pos_x) + IW'(1);
                                n_idx       = IW'(pos_x) + IW'(1);
                                n_state     = S_DOWN;
                            end
                        end
                        CMD_GET: begin
                            if (pos_x >= cnt_x) begin
                                n_status = ST_BAD_POS;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = IW'(pos_x);
                                n_state     = S_GET;
                            end
                        end
                        CMD_FIND: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                o_ram_re    = 1'b1;
                                o_ram_raddr = '0;
                                n_idx       = '0;
                                n_state     = S_FIND;
                            end
                        end
                        default: begin
                            n_status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_UP: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx + IW'(1);
                o_ram_wdata = i_ram_rdata;
                if (r_idx == r_pos) begin
                    n_state = S_PUT;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_idx - IW'(1);
                    n_idx       = r_idx - IW'(1);
                end
            end
            S_PUT: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_pos;
                o_ram_wdata = r_val;
                n_count     = r_count + CW'(1);
                n_state     = S_RESP;
            end
            S_DOWN: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_idx - IW'(1);
                o_ram_wdata = i_ram_rdata;
                if (r_idx == cnt_last) begin
                    n_count = r_count - CW'(1);
                    n_state = S_RESP;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_idx + IW'(1);
                    n_idx       = r_idx + IW'(1);
                end
            end
            S_GET: begin
                n_data  = i_ram_rdata;
                n_state = S_RESP;
            end
            S_FIND: begin
                if (i_ram_rdata == r_val) begin
                    n_fidx  = FIDX_W'(r_idx);
                    n_state = S_RESP;
                end else if (r_idx == cnt_last) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_RESP;
                end else begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = r_idx + IW'(1);
                    n_idx       = r_idx + IW'(1);
                end
            end
            S_RESP: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_status <= n_status;
        r_data   <= n_data;
        r_fidx   <= n_fidx;
    end

    assign o_idle             = (r_state == S_IDLE);
    assign o_res_valid        = (r_state == S_RESP);
    assign o_res.status       = r_status;
    assign o_res.data         = r_data;
    assign o_res.found_index  = r_fidx;
    assign o_res.count        = COUNT_W'(r_count);

endmodule

### sv/bounded_array_list.sv
// ----------------------------------------------------------------------------
// bounded_array_list
// Get reads the entry at the position; find reads from index zero until a
//   match or the last entry; insert with shift moves entries up from the last
//   one, then writes the value; remove with shift moves entries down.
// Refusals, appends and removal of the last entry need no walk. One command
//   at a time; walks use the single read and single write port of the RAM.
// Reset: synchronous active low; length cleared to zero, no RAM clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_array_list #(
    parameter int CAPACITY = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // command[1:0], position[9:2], value[41:10], zero pad[47:42]
    input  logic [bal_pkg::S_DATA_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[2:0], data[34:3], found_index[40:35], count[47:41]
    output logic [bal_pkg::M_DATA_W-1:0]    m_axis_tdata
);

    import bal_pkg::*;

    localparam int IW = $clog2(CAPACITY);

    logic              idle;
    logic              start;
    logic              res_valid;
    t_result           res;
    logic              out_free;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;

    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid & idle;
    assign out_free      = !r_m_valid || m_axis_tready;

    bal_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cmd       (t_cmd'(s_axis_tdata[1:0])),
        .i_pos       (s_axis_tdata[9:2]),
        .i_val       (s_axis_tdata[41:10]),
        .i_out_free  (out_free),
        .o_idle      (idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    bal_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_m_data <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
